FILE: src/tea_pkg.sv
`default_nettype none
package tea_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGIDITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA     = 1'b1;
  localparam logic [31:0] CFG_ONE = 32'h0001_0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEN0  = 2'd1;
  localparam logic [1:0] ST_AREA0 = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  // magnitude plus sign to a saturated 32-bit two's complement word
  function automatic sat_t sat_q16(input logic [95:0] mag, input logic neg);
    sat_t        r;
    logic [95:0] lim;
    logic [31:0] m32;
    lim   = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
    r.sat = mag > lim;
    m32   = r.sat ? lim[31:0] : mag[31:0];
    r.val = neg ? 32'd0 - m32 : m32;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/tea_div.sv
`default_nettype none
// Restoring divider, one quotient bit per stage. Quotient saturates to all
// ones when it does not fit in QW bits.
module tea_div #(
  parameter int NW = 100,
  parameter int DW = 67,
  parameter int QW = 33,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  localparam int CW = DW + QW;
  localparam int WW = (NW > CW) ? NW : CW;

  logic [NW-1:0] r_q  [QW];
  logic [DW-1:0] dn_q [QW];
  logic [QW-1:0] q_q  [1:QW];
  logic          ov_q [QW+1];
  logic [TW-1:0] tg_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= num_i;
      dn_q[0] <= den_i;
      ov_q[0] <= WW'(num_i) >= (WW'(den_i) << QW);
      tg_q[0] <= tag_i;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_bit
    localparam int B = QW - j;
    logic [WW-1:0] trial;
    logic [WW-1:0] rem_x;
    logic          take;
    logic [QW-1:0] q_in;

    assign trial = WW'(dn_q[j-1]) << B;
    assign rem_x = WW'(r_q[j-1]);
    assign take  = rem_x >= trial;

    if (j == 1) begin : g_first
      assign q_in = '0;
    end else begin : g_rest
      assign q_in = q_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[j]  <= q_in | (take ? (QW'(1) << B) : '0);
        ov_q[j] <= ov_q[j-1];
        tg_q[j] <= tg_q[j-1];
      end
    end

    if (j < QW) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[j]  <= take ? NW'(rem_x - trial) : r_q[j-1];
          dn_q[j] <= dn_q[j-1];
        end
      end
    end
  end

  assign quo_o = ov_q[QW] ? '1 : q_q[QW];
  assign tag_o = tg_q[QW];

endmodule
`default_nettype wire

FILE: src/tea_sqrt.sv
`default_nettype none
// Digit-by-digit floor square root, one root bit per stage.
module tea_sqrt #(
  parameter int AW = 66,
  parameter int TW = 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AW-1:0]   rad_i,
  input  logic [TW-1:0]   tag_i,
  output logic [AW/2-1:0] root_o,
  output logic [AW/2:0]   rem_o,
  output logic [TW-1:0]   tag_o
);

  localparam int RW = AW / 2;

  logic [AW-1:0] rem_q  [1:RW];
  logic [RW-1:0] root_q [1:RW];
  logic [TW-1:0] tg_q   [1:RW];

  for (genvar j = 1; j <= RW; j++) begin : g_bit
    localparam int B = RW - j;
    logic [AW-1:0] r_in;
    logic [RW-1:0] t_in;
    logic [TW-1:0] g_in;
    logic [AW-1:0] inc;
    logic          take;

    if (j == 1) begin : g_first
      assign r_in = rad_i;
      assign t_in = '0;
      assign g_in = tag_i;
    end else begin : g_rest
      assign r_in = rem_q[j-1];
      assign t_in = root_q[j-1];
      assign g_in = tg_q[j-1];
    end

    // (t + 2^B)^2 - t^2
    assign inc  = (AW'(t_in) << (B + 1)) | (AW'(1) << (2 * B));
    assign take = r_in >= inc;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? r_in - inc : r_in;
        root_q[j] <= t_in | (take ? (RW'(1) << B) : '0);
        tg_q[j]   <= g_in;
      end
    end
  end

  assign root_o = root_q[RW];
  assign rem_o  = rem_q[RW][RW:0];
  assign tag_o  = tg_q[RW];

endmodule
`default_nettype wire

FILE: src/truss_element_axial_force.sv
// Axial force of one 3D two-node truss element, values in Q16.16, all signed but the length.
// Input channel: in_valid_i / in_stall_o carry one element per beat (end
// coordinates and end displacements). Output channel: out_valid_o /
// out_stall_i carry force, stress, length, the plot vector and status.
// A beat moves on a rising edge with valid high and stall low.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 rigidity EA,
// 1 area A); write only while no element is in flight.
// Throughput: one element per cycle while the receiver does not stall. The
// pipeline has 100 register stages, and the longest path sets that depth:
// a 61-bit restoring divider for the direction fractions followed by a
// 31-bit square root, both one bit per stage.
// Reset clears every valid bit of the pipeline and sets EA and A to 1.0.
// When the receiver stalls a shown result, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Status: 0 ok, 1 zero length (all fields 0), 2 zero area (stress 0),
// 3 some field saturated.
`default_nettype none
module truss_element_axial_force (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             start_x_i,
  input  logic signed [31:0]             start_y_i,
  input  logic signed [31:0]             start_z_i,
  input  logic signed [31:0]             end_x_i,
  input  logic signed [31:0]             end_y_i,
  input  logic signed [31:0]             end_z_i,
  input  logic signed [31:0]             start_disp_x_i,
  input  logic signed [31:0]             start_disp_y_i,
  input  logic signed [31:0]             start_disp_z_i,
  input  logic signed [31:0]             end_disp_x_i,
  input  logic signed [31:0]             end_disp_y_i,
  input  logic signed [31:0]             end_disp_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             axial_force_o,
  output logic signed [31:0]             axial_stress_o,
  output logic [31:0]                    element_length_o,
  output logic signed [31:0]             plot_force_x_o,
  output logic signed [31:0]             plot_force_y_o,
  output logic signed [31:0]             plot_force_z_o,
  output logic [1:0]                     status_o
);
  import tea_pkg::*;

  localparam int QF        = 33;
  localparam int QR        = 61;
  localparam int RR        = 31;
  localparam int RL        = 33;
  localparam int FAC_LAT   = QR + 1 + RR;
  localparam int FORCE_LAT = 4 + QF + 1 + 1;
  localparam int LEN_LAT   = RL + 1;
  localparam int DLY_F     = FAC_LAT - FORCE_LAT;
  localparam int DLY_L     = FAC_LAT - LEN_LAT;
  localparam int TOTAL     = 3 + FAC_LAT + 4;

  typedef struct packed {
    logic [31:0] fbits;
    logic        fsat;
    logic [31:0] sbits;
    logic        ssat;
  } frc_t;

  typedef struct packed {
    logic [31:0] len;
    logic        lsat;
    logic        vert;
  } len_t;

  typedef struct packed {
    frc_t        f;
    len_t        l;
    logic        ddzero;
    logic        sx;
    logic        sy;
  } pl_t;

  logic adv;
  logic vld_q [TOTAL];

  assign adv        = !(vld_q[TOTAL-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[TOTAL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOTAL; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < TOTAL; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // configuration
  logic [31:0] rig_q, area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rig_q  <= CFG_ONE;
      area_q <= CFG_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RIGIDITY: rig_q  <= cfg_data_i;
        REG_AREA:     area_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: differences as magnitude and sign
  logic [31:0] st_c [3], en_c [3], su_c [3], eu_c [3];
  logic [31:0] ad_c [3], adu_c [3];
  logic        dn_c [3], un_c [3];

  assign st_c = '{start_x_i, start_y_i, start_z_i};
  assign en_c = '{end_x_i, end_y_i, end_z_i};
  assign su_c = '{start_disp_x_i, start_disp_y_i, start_disp_z_i};
  assign eu_c = '{end_disp_x_i, end_disp_y_i, end_disp_z_i};

  always_comb begin
    logic [32:0] dv, uv;
    for (int k = 0; k < 3; k++) begin
      dv = {en_c[k][31], en_c[k]} - {st_c[k][31], st_c[k]};
      uv = {eu_c[k][31], eu_c[k]} - {su_c[k][31], su_c[k]};
      dn_c[k]  = dv[32];
      un_c[k]  = uv[32];
      ad_c[k]  = dv[32] ? 32'(33'd0 - dv) : dv[31:0];
      adu_c[k] = uv[32] ? 32'(33'd0 - uv) : uv[31:0];
    end
  end

  logic [31:0] ad_q [3], adu_q [3];
  logic        dneg1_q [3], pneg1_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ad_q[k]    <= ad_c[k];
        adu_q[k]   <= adu_c[k];
        dneg1_q[k] <= dn_c[k];
        pneg1_q[k] <= dn_c[k] ^ un_c[k];
      end
    end
  end

  // stage 2: squares and products
  logic [63:0] sq2_q [3], pr2_q [3];
  logic        dneg2_q [3], pneg2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq2_q[k]   <= ad_q[k] * ad_q[k];
        pr2_q[k]   <= ad_q[k] * adu_q[k];
        dneg2_q[k] <= dneg1_q[k];
        pneg2_q[k] <= pneg1_q[k];
      end
    end
  end

  // stage 3: sums
  logic [64:0] hh_c;
  logic [65:0] dd_c, pos_c, neg_c;

  always_comb begin
    hh_c  = 65'(sq2_q[0]) + 65'(sq2_q[1]);
    dd_c  = 66'(hh_c) + 66'(sq2_q[2]);
    pos_c = '0;
    neg_c = '0;
    for (int k = 0; k < 3; k++) begin
      if (pneg2_q[k]) neg_c = neg_c + 66'(pr2_q[k]);
      else            pos_c = pos_c + 66'(pr2_q[k]);
    end
  end

  logic [64:0] hh3_q;
  logic [65:0] dd3_q, pos3_q, neg3_q;
  logic [63:0] sq3_q [3];
  logic        dneg3_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hh3_q  <= hh_c;
      dd3_q  <= dd_c;
      pos3_q <= pos_c;
      neg3_q <= neg_c;
      for (int k = 0; k < 3; k++) begin
        sq3_q[k]   <= sq2_q[k];
        dneg3_q[k] <= dneg2_q[k];
      end
    end
  end

  // force and stress path
  logic [65:0] dot4_q, dd4_q;
  logic        fneg4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fneg4_q <= pos3_q < neg3_q;
      dot4_q  <= (pos3_q < neg3_q) ? neg3_q - pos3_q : pos3_q - neg3_q;
      dd4_q   <= dd3_q;
    end
  end

  logic [63:0] pe0_q, pe1_q, pa0_q, pa1_q;
  logic [33:0] pe2_q, pa2_q;
  logic [65:0] dd5_q;
  logic        fneg5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pe0_q   <= rig_q * dot4_q[31:0];
      pe1_q   <= rig_q * dot4_q[63:32];
      pe2_q   <= rig_q * dot4_q[65:64];
      pa0_q   <= area_q * dd4_q[31:0];
      pa1_q   <= area_q * dd4_q[63:32];
      pa2_q   <= area_q * dd4_q[65:64];
      dd5_q   <= dd4_q;
      fneg5_q <= fneg4_q;
    end
  end

  logic [97:0] numf6_q, den6_q;
  logic [65:0] dd6_q;
  logic        fneg6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numf6_q <= 98'(pe0_q) + (98'(pe1_q) << 32) + (98'(pe2_q) << 64);
      den6_q  <= 98'(pa0_q) + (98'(pa1_q) << 32) + (98'(pa2_q) << 64);
      dd6_q   <= dd5_q;
      fneg6_q <= fneg5_q;
    end
  end

  // rounded division as floor((2n + d) / 2d)
  logic [99:0]  nf7_q;
  logic [66:0]  df7_q;
  logic [115:0] ns7_q;
  logic [98:0]  ds7_q;
  logic         fneg7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nf7_q   <= 100'({numf6_q, 1'b0}) + 100'(dd6_q);
      df7_q   <= {dd6_q, 1'b0};
      ns7_q   <= 116'({numf6_q, 17'b0}) + 116'(den6_q);
      ds7_q   <= {den6_q, 1'b0};
      fneg7_q <= fneg6_q;
    end
  end

  logic [QF-1:0] qf, qs;
  logic          tagf, tags;

  tea_div #(.NW(100), .DW(67), .QW(QF), .TW(1)) u_div_force (
    .clk_i (clk_i), .en_i (adv), .num_i (nf7_q), .den_i (df7_q),
    .tag_i (fneg7_q), .quo_o (qf), .tag_o (tagf)
  );

  tea_div #(.NW(116), .DW(99), .QW(QF), .TW(1)) u_div_stress (
    .clk_i (clk_i), .en_i (adv), .num_i (ns7_q), .den_i (ds7_q),
    .tag_i (fneg7_q), .quo_o (qs), .tag_o (tags)
  );

  sat_t fs_c, ss_c;
  frc_t frc_q;
  frc_t fdly_q [DLY_F];

  assign fs_c = sat_q16(96'(qf), tagf);
  assign ss_c = sat_q16(96'(qs), tags);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frc_q <= '{fbits: fs_c.val, fsat: fs_c.sat, sbits: ss_c.val, ssat: ss_c.sat};
      fdly_q[0] <= frc_q;
      for (int i = 1; i < DLY_F; i++) fdly_q[i] <= fdly_q[i-1];
    end
  end

  // length path
  logic [RL-1:0] lroot;
  logic [RL:0]   lrem;
  logic          lvert;
  logic [RL:0]   lrnd;
  len_t          len_q;
  len_t          ldly_q [DLY_L];

  tea_sqrt #(.AW(2 * RL), .TW(1)) u_sqrt_len (
    .clk_i (clk_i), .en_i (adv), .rad_i (dd3_q), .tag_i (hh3_q == '0),
    .root_o (lroot), .rem_o (lrem), .tag_o (lvert)
  );

  assign lrnd = (lrem > (RL + 1)'(lroot)) ? (RL + 1)'(lroot) + 1'b1 : (RL + 1)'(lroot);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_q.lsat <= lrnd[RL:32] != '0;
      len_q.len  <= (lrnd[RL:32] != '0) ? '1 : lrnd[31:0];
      len_q.vert <= lvert;
      ldly_q[0]  <= len_q;
      for (int i = 1; i < DLY_L; i++) ldly_q[i] <= ldly_q[i-1];
    end
  end

  // direction fractions with 30 fraction bits: sqrt(floor(n * 2^60 / m))
  logic [QR-1:0] qcz, qch, qex, qey;
  logic          t_cz, t_ch, t_ex, t_ey;
  logic [RR-1:0] cz, ch, ex, ey;
  logic          dneg2_f, ddzero_f, dneg0_f, dneg1_f;

  tea_div #(.NW(126), .DW(66), .QW(QR), .TW(1)) u_div_cz (
    .clk_i (clk_i), .en_i (adv), .num_i (126'({sq3_q[2], 60'b0})), .den_i (dd3_q),
    .tag_i (dneg3_q[2]), .quo_o (qcz), .tag_o (t_cz)
  );

  tea_div #(.NW(126), .DW(66), .QW(QR), .TW(1)) u_div_ch (
    .clk_i (clk_i), .en_i (adv), .num_i (126'({hh3_q, 60'b0})), .den_i (dd3_q),
    .tag_i (dd3_q == '0), .quo_o (qch), .tag_o (t_ch)
  );

  tea_div #(.NW(126), .DW(66), .QW(QR), .TW(1)) u_div_ex (
    .clk_i (clk_i), .en_i (adv), .num_i (126'({sq3_q[0], 60'b0})), .den_i (66'(hh3_q)),
    .tag_i (dneg3_q[0]), .quo_o (qex), .tag_o (t_ex)
  );

  tea_div #(.NW(126), .DW(66), .QW(QR), .TW(1)) u_div_ey (
    .clk_i (clk_i), .en_i (adv), .num_i (126'({sq3_q[1], 60'b0})), .den_i (66'(hh3_q)),
    .tag_i (dneg3_q[1]), .quo_o (qey), .tag_o (t_ey)
  );

  tea_sqrt #(.AW(2 * RR), .TW(1)) u_sqrt_cz (
    .clk_i (clk_i), .en_i (adv), .rad_i ((2 * RR)'(qcz)), .tag_i (t_cz),
    .root_o (cz), .rem_o (), .tag_o (dneg2_f)
  );

  tea_sqrt #(.AW(2 * RR), .TW(1)) u_sqrt_ch (
    .clk_i (clk_i), .en_i (adv), .rad_i ((2 * RR)'(qch)), .tag_i (t_ch),
    .root_o (ch), .rem_o (), .tag_o (ddzero_f)
  );

  tea_sqrt #(.AW(2 * RR), .TW(1)) u_sqrt_ex (
    .clk_i (clk_i), .en_i (adv), .rad_i ((2 * RR)'(qex)), .tag_i (t_ex),
    .root_o (ex), .rem_o (), .tag_o (dneg0_f)
  );

  tea_sqrt #(.AW(2 * RR), .TW(1)) u_sqrt_ey (
    .clk_i (clk_i), .en_i (adv), .rad_i ((2 * RR)'(qey)), .tag_i (t_ey),
    .root_o (ey), .rem_o (), .tag_o (dneg1_f)
  );

  // plot vector
  frc_t        fa;
  logic [31:0] fmag;
  pl_t         pl_c;

  assign fa   = fdly_q[DLY_F-1];
  assign fmag = fa.fbits[31] ? 32'd0 - fa.fbits : fa.fbits;

  always_comb begin
    pl_c.f      = fa;
    pl_c.l      = ldly_q[DLY_L-1];
    pl_c.ddzero = ddzero_f;
    pl_c.sx     = !(fa.fbits[31] ^ dneg0_f ^ dneg2_f);
    pl_c.sy     = !(fa.fbits[31] ^ dneg1_f ^ dneg2_f);
  end

  pl_t           p1_q, p2_q, p3_q;
  logic [62:0]   fz1_q, fc1_q, fc2_q;
  logic [RR-1:0] ex1_q, ey1_q;
  logic [62:0]   mxl_q, myl_q;
  logic [61:0]   mxh_q, myh_q;
  logic [95:0]   px_c, py_c;
  logic [63:0]   pz_c;
  logic [35:0]   px3_q, py3_q;
  logic [33:0]   pz3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q  <= pl_c;
      fz1_q <= fmag * cz;
      fc1_q <= fmag * ch;
      ex1_q <= ex;
      ey1_q <= ey;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q  <= p1_q;
      mxl_q <= fz1_q[31:0] * ex1_q;
      mxh_q <= fz1_q[62:32] * ex1_q;
      myl_q <= fz1_q[31:0] * ey1_q;
      myh_q <= fz1_q[62:32] * ey1_q;
      fc2_q <= fc1_q;
    end
  end

  // round half up on the magnitude
  assign px_c = 96'(mxl_q) + (96'(mxh_q) << 32) + (96'(1) << 59);
  assign py_c = 96'(myl_q) + (96'(myh_q) << 32) + (96'(1) << 59);
  assign pz_c = 64'(fc2_q) + (64'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_q  <= p2_q;
      px3_q <= px_c[95:60];
      py3_q <= py_c[95:60];
      pz3_q <= pz_c[63:30];
    end
  end

  // output register
  sat_t        sx_c, sy_c, sz_c;
  logic        sat_c;
  logic [31:0] frc_o_d, str_o_d, len_o_d, plx_d, ply_d, plz_d;
  logic [1:0]  st_d;

  assign sx_c = sat_q16(96'(px3_q), p3_q.sx);
  assign sy_c = sat_q16(96'(py3_q), p3_q.sy);
  assign sz_c = sat_q16(96'(pz3_q), p3_q.f.fbits[31]);

  always_comb begin
    sat_c = p3_q.f.fsat || p3_q.f.ssat || p3_q.l.lsat;
    if (p3_q.l.vert) begin
      plx_d = p3_q.f.fbits;
      ply_d = '0;
      plz_d = '0;
    end else begin
      plx_d = sx_c.val;
      ply_d = sy_c.val;
      plz_d = sz_c.val;
      sat_c = sat_c || sx_c.sat || sy_c.sat || sz_c.sat;
    end
    frc_o_d = p3_q.f.fbits;
    str_o_d = (area_q == '0) ? '0 : p3_q.f.sbits;
    len_o_d = p3_q.l.len;
    if (area_q == '0) st_d = ST_AREA0;
    else if (sat_c)   st_d = ST_SAT;
    else              st_d = ST_OK;
    if (p3_q.ddzero) begin
      frc_o_d = '0;
      str_o_d = '0;
      len_o_d = '0;
      plx_d   = '0;
      ply_d   = '0;
      plz_d   = '0;
      st_d    = ST_LEN0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      axial_force_o    <= frc_o_d;
      axial_stress_o   <= str_o_d;
      element_length_o <= len_o_d;
      plot_force_x_o   <= plx_d;
      plot_force_y_o   <= ply_d;
      plot_force_z_o   <= plz_d;
      status_o         <= st_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/tea_chk.sv
`default_nettype none
module tea_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] axial_force_o,
  input logic [31:0] axial_stress_o,
  input logic [31:0] element_length_o,
  input logic [31:0] plot_force_x_o,
  input logic [31:0] plot_force_y_o,
  input logic [31:0] plot_force_z_o,
  input logic [1:0]  status_o
);
  import tea_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(axial_force_o) &&
      $stable(status_o) && $stable(plot_force_x_o))
    else $error("stalled result changed");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  a_len0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_LEN0 |-> axial_force_o == '0 &&
      axial_stress_o == '0 && element_length_o == '0 && plot_force_x_o == '0 &&
      plot_force_y_o == '0 && plot_force_z_o == '0)
    else $error("zero-length element with nonzero fields");

  a_area0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_AREA0 |-> axial_stress_o == '0)
    else $error("zero area with nonzero stress");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> element_length_o != '0)
    else $error("good element with zero length");

endmodule

bind truss_element_axial_force tea_chk u_tea_chk (.*);
`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tea_pkg::*;

  localparam int LATENCY = 110;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 275;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [31:0] sx, sy, sz, ex, ey, ez;
    logic [31:0] usx, usy, usz, uex, uey, uez;
  } elem_t;

  typedef struct packed {
    logic [31:0] force_q, stress_q, len_q, px, py, pz;
    logic [1:0]  st;
  } res_t;

  typedef struct packed {
    elem_t el;
    bit    typed;
    res_t  res;
  } row_t;

  localparam logic [31:0] MIN = 32'h8000_0000;
  localparam logic [31:0] MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] M1  = 32'hFFFF_0000;

  localparam int N_DIR = 18;
  // typed rows: zero length (all fields zero) and a unit bar along x
  // stretched by one unit (force, stress, length and plot z all 1.0)
  row_t dir_tab [N_DIR] = '{
    '{'{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1'b1, '{0,0,0,0,0,0,ST_LEN0}},
    '{'{0,0,0, ONE,0,0, 0,0,0, ONE,0,0}, 1'b1, '{ONE,ONE,ONE,0,0,ONE,ST_OK}},
    '{'{MAX,MAX,MAX, MAX,MAX,MAX, MIN,MAX,0, MAX,MIN,1}, 1'b1,
      '{0,0,0,0,0,0,ST_LEN0}},
    '{'{MIN,MIN,MIN, MAX,MAX,MAX, MIN,MIN,MIN, MAX,MAX,MAX}, 1'b0, '0},
    '{'{MAX,MAX,MAX, MIN,MIN,MIN, MAX,MAX,MAX, MIN,MIN,MIN}, 1'b0, '0},
    '{'{MAX,MIN,0, MIN,MAX,0, MIN,MAX,0, MAX,MIN,0}, 1'b0, '0},
    '{'{0,0,0, 0,0,ONE, 0,0,0, 0,0,ONE}, 1'b0, '0},
    '{'{0,0,ONE, 0,0,0, 0,0,0, ONE,ONE,M1}, 1'b0, '0},
    '{'{0,0,MIN, 0,0,MAX, 0,0,MIN, 0,0,MAX}, 1'b0, '0},
    '{'{0,0,0, M1,M1,M1, 0,0,0, ONE,ONE,ONE}, 1'b0, '0},
    '{'{0,0,0, ONE,ONE,0, 0,0,0, M1,0,0}, 1'b0, '0},
    '{'{0,0,0, 0,ONE,0, 0,0,0, 0,MAX,0}, 1'b0, '0},
    '{'{ONE,ONE,ONE, 0,0,0, 0,0,0, 0,0,0}, 1'b0, '0},
    '{'{0,0,0, 1,0,0, 0,0,0, MAX,0,0}, 1'b0, '0},
    '{'{0,0,0, 1,1,1, MIN,MIN,MIN, MAX,MAX,MAX}, 1'b0, '0},
    '{'{0,0,0, MAX,1,M1, 32'h1234_5678,0,0, 32'hFFFF_FFFF,ONE,ONE}, 1'b0, '0},
    '{'{32'hFFFF_FFFF,0,0, 0,0,0, 0,0,0, 0,0,0}, 1'b0, '0},
    '{'{0,ONE,0, 0,0,ONE, 0,M1,0, 0,0,ONE}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_RIGIDITY;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  elem_t drv = '0;
  logic in_stall;
  logic out_valid;
  res_t got;

  logic [31:0] rigidity = CFG_ONE;
  logic [31:0] area = CFG_ONE;
  row_t cur_row = '0;
  res_t expected_q [$];
  int errors = 0;
  int cycles = 0;
  bit idling = 1'b1;
  bit hold_req = 1'b0;

  truss_element_axial_force i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .start_x_i(drv.sx), .start_y_i(drv.sy), .start_z_i(drv.sz),
    .end_x_i(drv.ex), .end_y_i(drv.ey), .end_z_i(drv.ez),
    .start_disp_x_i(drv.usx), .start_disp_y_i(drv.usy), .start_disp_z_i(drv.usz),
    .end_disp_x_i(drv.uex), .end_disp_y_i(drv.uey), .end_disp_z_i(drv.uez),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .axial_force_o(got.force_q), .axial_stress_o(got.stress_q),
    .element_length_o(got.len_q), .plot_force_x_o(got.px),
    .plot_force_y_o(got.py), .plot_force_z_o(got.pz), .status_o(got.st)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(input logic [127:0] a);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= a) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] saturate(input logic [127:0] m, input bit neg,
                                           inout bit sat);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (m > lim) begin
      m = lim;
      sat = 1'b1;
    end
    return neg ? 32'd0 - m[31:0] : m[31:0];
  endfunction

  function automatic res_t axial_result(input elem_t el);
    res_t r;
    logic [31:0] v [12];
    longint d [3];
    longint du [3];
    logic [127:0] ad [3];
    logic [127:0] adu [3];
    logic [127:0] hh, dd, pos, negs, dot, numf, q, den, fmag, fz;
    logic [63:0] len, cz, ch, exf, eyf;
    bit dneg [3];
    bit sat, fneg;
    r = '0;
    sat = 1'b0;
    for (int k = 0; k < 12; k++) v[k] = el[383 - 32*k -: 32];
    for (int k = 0; k < 3; k++) begin
      d[k] = longint'(signed'(v[3+k])) - longint'(signed'(v[k]));
      du[k] = longint'(signed'(v[9+k])) - longint'(signed'(v[6+k]));
      dneg[k] = d[k] < 0;
      ad[k] = 128'(d[k] < 0 ? -d[k] : d[k]);
      adu[k] = 128'(du[k] < 0 ? -du[k] : du[k]);
    end
    hh = ad[0]*ad[0] + ad[1]*ad[1];
    dd = hh + ad[2]*ad[2];
    if (dd == 0) begin
      r.st = ST_LEN0;
      return r;
    end
    len = floor_sqrt(dd);
    if (dd - {64'd0, len} * {64'd0, len} > {64'd0, len}) len++;
    if (len > 64'hFFFF_FFFF) begin
      len = 64'hFFFF_FFFF;
      sat = 1'b1;
    end
    r.len_q = len[31:0];
    pos = '0;
    negs = '0;
    for (int k = 0; k < 3; k++) begin
      if ((d[k] < 0) != (du[k] < 0)) negs += ad[k]*adu[k];
      else pos += ad[k]*adu[k];
    end
    fneg = pos < negs;
    dot = fneg ? negs - pos : pos - negs;
    numf = {96'd0, rigidity} * dot;
    q = (2*numf + dd) / (2*dd);
    r.force_q = saturate(q, fneg, sat);
    if (area != 0) begin
      den = dd * {96'd0, area};
      q = (2*(numf << 16) + den) / (2*den);
      r.stress_q = saturate(q, fneg, sat);
    end
    fneg = r.force_q[31];
    fmag = fneg ? 128'(33'h1_0000_0000 - {1'b0, r.force_q}) : {96'd0, r.force_q};
    if (ad[0] == 0 && ad[1] == 0) begin
      r.px = r.force_q;
    end else begin
      cz = floor_sqrt(((ad[2]*ad[2]) << 60) / dd);
      ch = floor_sqrt((hh << 60) / dd);
      exf = floor_sqrt(((ad[0]*ad[0]) << 60) / hh);
      eyf = floor_sqrt(((ad[1]*ad[1]) << 60) / hh);
      fz = fmag * {64'd0, cz};
      q = (fz * {64'd0, exf} + (128'd1 << 59)) >> 60;
      r.px = saturate(q, !(fneg ^ dneg[0] ^ dneg[2]), sat);
      q = (fz * {64'd0, eyf} + (128'd1 << 59)) >> 60;
      r.py = saturate(q, !(fneg ^ dneg[1] ^ dneg[2]), sat);
      q = (fmag * {64'd0, ch} + (128'd1 << 29)) >> 30;
      r.pz = saturate(q, fneg, sat);
    end
    r.st = area == 0 ? ST_AREA0 : (sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  // sample just before the edge that moves the beat
  always @(negedge clk) begin
    res_t e;
    if (rst_n && in_valid && !in_stall)
      expected_q.push_back(cur_row.typed ? cur_row.res : axial_result(cur_row.el));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (got.force_q !== e.force_q) begin
          $error("axial_force exp %h got %h", e.force_q, got.force_q); errors++;
        end
        if (got.stress_q !== e.stress_q) begin
          $error("axial_stress exp %h got %h", e.stress_q, got.stress_q); errors++;
        end
        if (got.len_q !== e.len_q) begin
          $error("element_length exp %h got %h", e.len_q, got.len_q); errors++;
        end
        if (got.px !== e.px) begin
          $error("plot_force_x exp %h got %h", e.px, got.px); errors++;
        end
        if (got.py !== e.py) begin
          $error("plot_force_y exp %h got %h", e.py, got.py); errors++;
        end
        if (got.pz !== e.pz) begin
          $error("plot_force_z exp %h got %h", e.pz, got.pz); errors++;
        end
        if (got.st !== e.st) begin
          $error("status exp %0d got %0d", e.st, got.st); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver side
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the beat
  task automatic send_beat(input row_t row);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    cur_row = row;
    drv <= row.el;
    in_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == REG_RIGIDITY) rigidity = val;
    else area = val;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return MIN;
      1: return MAX;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? ONE : M1;
      default: return $urandom();
    endcase
  endfunction

  function automatic elem_t random_elem();
    elem_t el;
    int mode;
    mode = $urandom_range(0, 9);
    el = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
          $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    if (mode <= 3) begin
      // realistic geometry: coordinates and x displacements of modest size
      el.sx = 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      el.sy = 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      el.sz = 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      el.ex = 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      el.ey = 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      el.ez = 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      el.usx = 32'(signed'($urandom_range(0, 1 << 14)) - (1 << 13));
      el.uex = 32'(signed'($urandom_range(0, 1 << 14)) - (1 << 13));
    end else if (mode == 6) begin
      el.ex = el.sx;
      el.ey = el.sy;
    end else if (mode == 7) begin
      el.ex = el.sx;
      el.ey = el.sy;
      el.ez = el.sz;
    end else if (mode == 8) begin
      el.ez = el.sz;
      if ($urandom_range(0, 1)) el.ey = el.sy;
    end else if (mode == 9) begin
      el = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
            pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
            pick_word(), pick_word()};
    end
    return el;
  endfunction

  initial begin
    logic [31:0] ea_set [7];
    logic [31:0] a_set [7];
    row_t row;
    ea_set = '{32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0};
    a_set  = '{32'hFFFF_FFFF, CFG_ONE, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 32'h0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph >= 4) begin
        ea_set[ph] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 1 << 22);
        a_set[ph] = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 1 << 20);
      end
      write_reg(REG_RIGIDITY, ea_set[ph]);
      write_reg(REG_AREA, a_set[ph]);
      cfg_we <= 1'b0;
      idling = ph != 6;
      // phase 4 fills the pipeline against a long receiver hold
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < (ph < 6 ? PHASE_ITEMS : 2 * PHASE_ITEMS / 3); n++) begin
        row = '0;
        row.el = random_elem();
        send_beat(row);
      end
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
src/tea_pkg.sv
src/tea_div.sv
src/tea_sqrt.sv
src/truss_element_axial_force.sv
src/tea_chk.sv
sim/testbench.sv
